// ===== rtl/core/vss_pkg.sv =====
package vss_pkg;

  // Defaults for the top level parameters
  localparam int MAX_SATS_DEF   = 64;
  localparam int COORD_BITS_DEF = 28;

  // Fixed field widths
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 56;
  localparam int THR_W       = 56;
  localparam int SAT_INDEX_W = 6;
  localparam int OUT_DATA_W  = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USER_X,
    REG_USER_Y,
    REG_USER_Z,
    REG_HORIZON,
    REG_CONE
  } cfg_reg_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_PREP,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Steps of the shared multiplier
  typedef enum logic [4:0] {
    MS_US_X, MS_US_Y, MS_US_Z,
    MS_UB_X, MS_UB_Y, MS_UB_Z,
    MS_BL_X, MS_BL_Y, MS_BL_Z,
    MS_L_LL, MS_L_HL, MS_L_HH,
    MS_R_LL, MS_R_LH, MS_R_HL, MS_R_HH,
    MS_FLUSH,
    MS_CMP
  } mul_step_t;

endpackage

// ===== rtl/core/visible_satellite_select_sort.sv =====
// Visible satellite selection. Satellites are loaded one request at a time;
// each load runs 16 multiplies on one shared 33x33 multiplier plus a flush
// and a compare before the next satellite can be taken (a satellite beyond
// MAX_SATS is dropped without a calculation). Squared beam lengths sit in a
// single-port-read memory; on the request marked tlast the visible
// satellites are emitted nearest first, ties to the lower index, each result
// found by a scan over all MAX_SATS entries through the memory read port,
// and an output stall holds the emit. With nothing visible one result with
// found clear is given. Overflow flags runs in which satellites were
// dropped.
module visible_satellite_select_sort #(
  parameter int MAX_SATS   = vss_pkg::MAX_SATS_DEF,
  parameter int COORD_BITS = vss_pkg::COORD_BITS_DEF,
  localparam int IN_DATA_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // sat_x, sat_y, sat_z from bit 0 up, zero padded
  input  logic [IN_DATA_W-1:0]            s_tdata,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // sat_index, found, overflow from bit 0 up
  output logic [vss_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vss_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W  = $clog2(MAX_SATS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int BLEN_W = 2 * COORD_BITS + 2;

  vss_pkg::state_t state, state_next;

  logic signed [COORD_BITS-1:0] user_x, user_y, user_z;
  logic [vss_pkg::THR_W-1:0]    horizon_radius_sq, cone_threshold;
  logic [CNT_W-1:0]             load_count, scan_cnt;
  logic                         dropped_flag, is_last;
  logic [MAX_SATS-1:0]          visible_marks, pending, pending_rest;
  logic                         rd_vld, have;
  logic [IDX_W-1:0]             rd_tag, best_idx;
  logic [BLEN_W-1:0]            best_val, rd_data, calc_blen;
  logic                         calc_done, calc_vis;
  logic                         accept, room, issue, scan_end, out_free, final_res;

  assign accept       = s_tvalid && s_tready;
  assign room         = load_count < CNT_W'(MAX_SATS);
  assign issue        = (state == vss_pkg::ST_SCAN) && (scan_cnt != CNT_W'(MAX_SATS));
  assign scan_end     = (scan_cnt == CNT_W'(MAX_SATS)) && !rd_vld;
  assign out_free     = !m_tvalid || m_tready;
  assign pending_rest = pending & ~(MAX_SATS'(1) << best_idx);
  assign final_res    = !have || (pending_rest == '0);
  assign cfg_ready    = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      user_x            <= '0;
      user_y            <= '0;
      user_z            <= '0;
      horizon_radius_sq <= '0;
      cone_threshold    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (vss_pkg::cfg_reg_t'(cfg_index))
        vss_pkg::REG_USER_X:  user_x <= cfg_data[COORD_BITS-1:0];
        vss_pkg::REG_USER_Y:  user_y <= cfg_data[COORD_BITS-1:0];
        vss_pkg::REG_USER_Z:  user_z <= cfg_data[COORD_BITS-1:0];
        vss_pkg::REG_HORIZON: horizon_radius_sq <= cfg_data[vss_pkg::THR_W-1:0];
        vss_pkg::REG_CONE:    cone_threshold <= cfg_data[vss_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Visibility datapath
  vss_calc #(.COORD_BITS(COORD_BITS)) u_calc (
    .clk               (clk),
    .rst               (rst),
    .start             (accept && room),
    .sat_x             (s_tdata[COORD_BITS-1:0]),
    .sat_y             (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .sat_z             (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .user_x            (user_x),
    .user_y            (user_y),
    .user_z            (user_z),
    .horizon_radius_sq (horizon_radius_sq),
    .cone_threshold    (cone_threshold),
    .done              (calc_done),
    .vis               (calc_vis),
    .blen              (calc_blen)
  );

  // Squared beam length store
  vss_mem #(.DEPTH(MAX_SATS), .WIDTH(BLEN_W)) u_mem (
    .clk   (clk),
    .we    ((state == vss_pkg::ST_CALC) && calc_done),
    .waddr (load_count[IDX_W-1:0]),
    .wdata (calc_blen),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      vss_pkg::ST_IDLE:
        if (accept) begin
          if (room)         state_next = vss_pkg::ST_CALC;
          else if (s_tlast) state_next = vss_pkg::ST_PREP;
        end
      vss_pkg::ST_CALC:
        if (calc_done) state_next = is_last ? vss_pkg::ST_PREP : vss_pkg::ST_IDLE;
      vss_pkg::ST_PREP:
        state_next = (visible_marks == '0) ? vss_pkg::ST_EMIT : vss_pkg::ST_SCAN;
      vss_pkg::ST_SCAN:
        if (scan_end) state_next = vss_pkg::ST_EMIT;
      vss_pkg::ST_EMIT:
        if (out_free) state_next = final_res ? vss_pkg::ST_IDLE : vss_pkg::ST_SCAN;
      default:
        state_next = vss_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_tready = (state == vss_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= vss_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Run bookkeeping and scan
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count    <= '0;
      dropped_flag  <= 1'b0;
      visible_marks <= '0;
      rd_vld        <= 1'b0;
      have          <= 1'b0;
      scan_cnt      <= '0;
    end else begin
      rd_vld <= issue;
      rd_tag <= scan_cnt[IDX_W-1:0];
      unique case (state)
        vss_pkg::ST_IDLE:
          if (accept) begin
            is_last <= s_tlast;
            if (!room) dropped_flag <= 1'b1;
          end
        vss_pkg::ST_CALC:
          if (calc_done) begin
            visible_marks[load_count[IDX_W-1:0]] <= calc_vis;
            load_count <= load_count + 1'b1;
          end
        vss_pkg::ST_PREP: begin
          pending  <= visible_marks;
          have     <= 1'b0;
          scan_cnt <= '0;
        end
        vss_pkg::ST_SCAN: begin
          if (issue) scan_cnt <= scan_cnt + 1'b1;
          // strict compare keeps the lower index on ties
          if (rd_vld && pending[rd_tag] && (!have || rd_data < best_val)) begin
            have     <= 1'b1;
            best_idx <= rd_tag;
            best_val <= rd_data;
          end
        end
        vss_pkg::ST_EMIT:
          if (out_free) begin
            if (final_res) begin
              visible_marks <= '0;
              load_count    <= '0;
              dropped_flag  <= 1'b0;
            end else begin
              pending  <= pending_rest;
              have     <= 1'b0;
              scan_cnt <= '0;
            end
          end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if ((state == vss_pkg::ST_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {dropped_flag, have,
                     have ? vss_pkg::SAT_INDEX_W'(best_idx) : vss_pkg::SAT_INDEX_W'(0)};
        m_tlast  <= final_res;
      end
    end
  end

endmodule

// ===== rtl/core/vss_mem.sv =====
module vss_mem #(
  parameter int DEPTH = vss_pkg::MAX_SATS_DEF,
  parameter int WIDTH = 2 * vss_pkg::COORD_BITS_DEF + 2,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/vss_calc.sv =====
module vss_calc #(
  parameter int COORD_BITS = vss_pkg::COORD_BITS_DEF,
  localparam int BLEN_W    = 2 * COORD_BITS + 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [COORD_BITS-1:0]   sat_x,
  input  logic signed [COORD_BITS-1:0]   sat_y,
  input  logic signed [COORD_BITS-1:0]   sat_z,
  input  logic signed [COORD_BITS-1:0]   user_x,
  input  logic signed [COORD_BITS-1:0]   user_y,
  input  logic signed [COORD_BITS-1:0]   user_z,
  input  logic [vss_pkg::THR_W-1:0]      horizon_radius_sq,
  input  logic [vss_pkg::THR_W-1:0]      cone_threshold,
  output logic                           done,
  output logic                           vis,
  output logic [BLEN_W-1:0]              blen
);

  localparam int OP_W = 33;

  vss_pkg::mul_step_t step;
  vss_pkg::mul_step_t ptag;
  logic busy;

  logic signed [COORD_BITS-1:0] sx, sy, sz;
  logic signed [COORD_BITS:0]   bx, by, bz;
  logic signed [OP_W-1:0]       op_a, op_b;
  logic signed [2*OP_W-1:0]     prod;
  logic [63:0]                  us, ub, bl;
  logic [127:0]                 lacc, racc;

  // Step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= vss_pkg::MS_US_X;
    end else if (start) begin
      busy <= 1'b1;
      step <= vss_pkg::MS_US_X;
    end else if (busy) begin
      if (step == vss_pkg::MS_CMP) begin
        busy <= 1'b0;
      end else begin
        step <= vss_pkg::mul_step_t'(step + 5'd1);
      end
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step)
      vss_pkg::MS_US_X: begin op_a = OP_W'(user_x); op_b = OP_W'(sx); end
      vss_pkg::MS_US_Y: begin op_a = OP_W'(user_y); op_b = OP_W'(sy); end
      vss_pkg::MS_US_Z: begin op_a = OP_W'(user_z); op_b = OP_W'(sz); end
      vss_pkg::MS_UB_X: begin op_a = OP_W'(user_x); op_b = OP_W'(bx); end
      vss_pkg::MS_UB_Y: begin op_a = OP_W'(user_y); op_b = OP_W'(by); end
      vss_pkg::MS_UB_Z: begin op_a = OP_W'(user_z); op_b = OP_W'(bz); end
      vss_pkg::MS_BL_X: begin op_a = OP_W'(bx); op_b = OP_W'(bx); end
      vss_pkg::MS_BL_Y: begin op_a = OP_W'(by); op_b = OP_W'(by); end
      vss_pkg::MS_BL_Z: begin op_a = OP_W'(bz); op_b = OP_W'(bz); end
      vss_pkg::MS_L_LL: begin
        op_a = {1'b0, ub[31:0]};
        op_b = {1'b0, ub[31:0]};
      end
      vss_pkg::MS_L_HL: begin
        op_a = {1'b0, ub[63:32]};
        op_b = {1'b0, ub[31:0]};
      end
      vss_pkg::MS_L_HH: begin
        op_a = {1'b0, ub[63:32]};
        op_b = {1'b0, ub[63:32]};
      end
      vss_pkg::MS_R_LL: begin
        op_a = {1'b0, cone_threshold[31:0]};
        op_b = {1'b0, bl[31:0]};
      end
      vss_pkg::MS_R_LH: begin
        op_a = {1'b0, cone_threshold[31:0]};
        op_b = {1'b0, bl[63:32]};
      end
      vss_pkg::MS_R_HL: begin
        op_a = {9'b0, cone_threshold[55:32]};
        op_b = {1'b0, bl[31:0]};
      end
      vss_pkg::MS_R_HH: begin
        op_a = {9'b0, cone_threshold[55:32]};
        op_b = {1'b0, bl[63:32]};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Registered product, then accumulate by the tag of its step
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (start) begin
      sx   <= sat_x;
      sy   <= sat_y;
      sz   <= sat_z;
      bx   <= (COORD_BITS+1)'(sat_x) - (COORD_BITS+1)'(user_x);
      by   <= (COORD_BITS+1)'(sat_y) - (COORD_BITS+1)'(user_y);
      bz   <= (COORD_BITS+1)'(sat_z) - (COORD_BITS+1)'(user_z);
      us   <= '0;
      ub   <= '0;
      bl   <= '0;
      lacc <= '0;
      racc <= '0;
      ptag <= vss_pkg::MS_FLUSH;
    end else if (busy) begin
      ptag <= step;
      unique case (ptag)
        vss_pkg::MS_US_X, vss_pkg::MS_US_Y, vss_pkg::MS_US_Z:
          us <= us + prod[63:0];
        vss_pkg::MS_UB_X, vss_pkg::MS_UB_Y, vss_pkg::MS_UB_Z:
          ub <= ub + prod[63:0];
        vss_pkg::MS_BL_X, vss_pkg::MS_BL_Y, vss_pkg::MS_BL_Z:
          bl <= bl + prod[63:0];
        vss_pkg::MS_L_LL: lacc <= lacc + 128'(prod[63:0]);
        // cross term counts twice
        vss_pkg::MS_L_HL: lacc <= lacc + (128'(prod[63:0]) << 33);
        vss_pkg::MS_L_HH: lacc <= lacc + (128'(prod[63:0]) << 64);
        vss_pkg::MS_R_LL: racc <= racc + 128'(prod[63:0]);
        vss_pkg::MS_R_LH, vss_pkg::MS_R_HL:
          racc <= racc + (128'(prod[63:0]) << 32);
        vss_pkg::MS_R_HH: racc <= racc + (128'(prod[63:0]) << 64);
        default: begin
        end
      endcase
    end
  end

  // Final tests
  assign done = busy && (step == vss_pkg::MS_CMP);
  assign vis  = ($signed(us) >= $signed({8'b0, horizon_radius_sq}))
             && ($signed(ub) > 64'sd0)
             && (lacc >= racc);
  assign blen = bl[BLEN_W-1:0];

endmodule

// ===== rtl/core/vss_checker.sv =====
module vss_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed under stall");

  // Not found closes the run
  a_nf_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[6] |-> m_tlast)
    else $error("not found result without tlast");

  // Not found carries index zero
  a_nf_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[6] |-> m_tdata[5:0] == 6'd0)
    else $error("not found result with index");

  // Nothing is shown just after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind visible_satellite_select_sort vss_checker u_vss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== tb/visible_satellite_select_chk.sv =====
module visible_satellite_select_chk #(
  parameter int MAX_SATS   = vss_pkg::MAX_SATS_DEF,
  parameter int COORD_BITS = vss_pkg::COORD_BITS_DEF,
  localparam int IN_DATA_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [IN_DATA_W-1:0]            s_tdata,
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [vss_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            m_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [vss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vss_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fails,
  output int                              pending
);
  import vss_pkg::*;

  typedef struct packed {
    logic [SAT_INDEX_W-1:0] sat_index;
    logic                   found;
    logic                   last_result;
    logic                   overflow;
  } sat_result_t;

  // Model copy of the configuration and run state
  longint             usr_x, usr_y, usr_z;
  logic [THR_W-1:0]   horizon_sq, cone_thr;
  logic [63:0]        beam_len_sq [MAX_SATS];
  logic [MAX_SATS-1:0] vis_marks;
  int                 sats_held;
  logic               sats_dropped;
  sat_result_t        nearest_q [$];

  function automatic longint coord(input logic [COORD_BITS-1:0] v);
    logic signed [COORD_BITS-1:0] s;
    s = v;
    return s;
  endfunction

  // Visibility test and squared beam length of one satellite
  task automatic store_sat(input logic [IN_DATA_W-1:0] d);
    longint      sx, sy, sz, bx, by, bz, dot_us, dot_ub;
    logic [63:0] blen, dub;
    logic [127:0] lhs, rhs;
    sx = coord(d[COORD_BITS-1:0]);
    sy = coord(d[2*COORD_BITS-1:COORD_BITS]);
    sz = coord(d[3*COORD_BITS-1:2*COORD_BITS]);
    bx = sx - usr_x;
    by = sy - usr_y;
    bz = sz - usr_z;
    dot_us = usr_x * sx + usr_y * sy + usr_z * sz;
    dot_ub = usr_x * bx + usr_y * by + usr_z * bz;
    blen = bx * bx + by * by + bz * bz;
    beam_len_sq[sats_held] = blen;
    if (dot_us >= longint'({8'b0, horizon_sq}) && dot_ub > 0) begin
      dub = dot_ub;
      lhs = 128'(dub) * 128'(dub);
      rhs = 128'(cone_thr) * 128'(blen);
      if (lhs >= rhs) vis_marks[sats_held] = 1'b1;
    end
    sats_held++;
  endtask

  // Nearest-first order of the visible set, ties to the lower index
  task automatic queue_nearest();
    logic [MAX_SATS-1:0] left;
    int                  best;
    sat_result_t         r;
    left = vis_marks;
    if (left == '0) begin
      r = '{sat_index: '0, found: 1'b0, last_result: 1'b1, overflow: sats_dropped};
      nearest_q.push_back(r);
    end
    while (left != '0) begin
      best = -1;
      for (int i = 0; i < MAX_SATS; i++)
        if (left[i] && (best < 0 || beam_len_sq[i] < beam_len_sq[best])) best = i;
      left[best] = 1'b0;
      r = '{sat_index: best[SAT_INDEX_W-1:0], found: 1'b1, last_result: (left == '0),
            overflow: sats_dropped};
      nearest_q.push_back(r);
    end
    vis_marks = '0;
    sats_held = 0;
    sats_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    sat_result_t e;
    int          nf;
    nf = 0;
    if (rst) begin
      usr_x = 0; usr_y = 0; usr_z = 0;
      horizon_sq = '0; cone_thr = '0;
      vis_marks = '0; sats_held = 0; sats_dropped = 1'b0;
      nearest_q.delete();
      fails <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_USER_X:  usr_x = coord(cfg_data[COORD_BITS-1:0]);
          REG_USER_Y:  usr_y = coord(cfg_data[COORD_BITS-1:0]);
          REG_USER_Z:  usr_z = coord(cfg_data[COORD_BITS-1:0]);
          REG_HORIZON: horizon_sq = cfg_data[THR_W-1:0];
          REG_CONE:    cone_thr = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      // satellite requests
      if (s_tvalid && s_tready) begin
        if (sats_held < MAX_SATS) store_sat(s_tdata);
        else sats_dropped = 1'b1;
        if (s_tlast) queue_nearest();
      end
      // results
      if (m_tvalid && m_tready) begin
        if (nearest_q.size() == 0) begin
          $error("unexpected result: sat_index %0d found %0b", m_tdata[5:0], m_tdata[6]);
          nf++;
        end else begin
          e = nearest_q.pop_front();
          if (m_tdata[SAT_INDEX_W-1:0] !== e.sat_index) begin
            $error("sat_index: expected %0d, got %0d", e.sat_index, m_tdata[5:0]);
            nf++;
          end
          if (m_tdata[SAT_INDEX_W] !== e.found) begin
            $error("found: expected %0b, got %0b", e.found, m_tdata[SAT_INDEX_W]);
            nf++;
          end
          if (m_tdata[SAT_INDEX_W+1] !== e.overflow) begin
            $error("overflow: expected %0b, got %0b", e.overflow, m_tdata[SAT_INDEX_W+1]);
            nf++;
          end
          if (m_tlast !== e.last_result) begin
            $error("last_result: expected %0b, got %0b", e.last_result, m_tlast);
            nf++;
          end
        end
      end
      fails <= fails + nf;
    end
    pending <= nearest_q.size();
  end

endmodule

// ===== tb/tb_visible_satellite_select_sort.sv =====
module tb_visible_satellite_select_sort;
  import vss_pkg::*;

  localparam int CB        = COORD_BITS_DEF;
  localparam int IN_DATA_W = ((3 * CB + 7) / 8) * 8;
  localparam longint CMAX  = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint CMIN  = -(64'sd1 <<< (CB - 1));
  localparam longint THR_MAX = 64'd54043195528445952;
  localparam int IDLE_LIMIT  = 12000;
  localparam int HOLD_CYCLES = 3000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // sat_x, sat_y, sat_z from bit 0 up, zero padded
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // sat_index, found, overflow from bit 0 up
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int     fails, pending, idle_cycles, sats_sent;
  bit     hold_req = 1'b0;
  bit     quiet = 1'b0;
  longint axis_r;
  int     axis_sign;
  logic [IN_DATA_W-1:0] prev_sat = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  visible_satellite_select_sort i_dut (.*);

  visible_satellite_select_chk i_chk (.*);

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result receiver: random stalls plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        for (int i = 1; i < HOLD_CYCLES; i++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no request moving anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_user(input longint x, input longint y, input longint z);
    write_reg(REG_USER_X, CFG_DATA_W'(x));
    write_reg(REG_USER_Y, CFG_DATA_W'(y));
    write_reg(REG_USER_Z, CFG_DATA_W'(z));
  endtask

  task automatic send_sat(input longint x, input longint y, input longint z, input bit last);
    int n;
    n = gap_len();
    @(negedge clk);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({z[CB-1:0], y[CB-1:0], x[CB-1:0]});
    prev_sat = IN_DATA_W'({z[CB-1:0], y[CB-1:0], x[CB-1:0]});
    s_tlast  <= last;
    sats_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  // block idle: all results in and the emit finished
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  function automatic longint coord_of(input logic [31:0] v);
    logic signed [CB-1:0] s;
    s = v[CB-1:0];
    return s;
  endfunction

  function automatic longint rnd_coord();
    return coord_of($urandom());
  endfunction

  // user on a signed z axis, horizon and cone set to pass nearby satellites
  task automatic geometric_config();
    longint off_x, off_y, hz;
    axis_r    = $urandom_range(1 << 20, 1 << 26);
    axis_sign = $urandom_range(0, 1) ? 1 : -1;
    off_x = $signed($urandom_range(0, 8191)) - 4096;
    off_y = $signed($urandom_range(0, 8191)) - 4096;
    set_user(off_x, off_y, axis_sign * axis_r);
    hz = axis_r * axis_r - longint'($urandom_range(0, 1 << 30));
    write_reg(REG_HORIZON, CFG_DATA_W'(hz < 0 ? 0 : hz));
    write_reg(REG_CONE, CFG_DATA_W'((axis_r * axis_r / 16) * $urandom_range(0, 15)));
  endtask

  // satellite near the user's zenith, or noise, or a repeat for ties
  task automatic random_sat(input bit last);
    int p;
    logic signed [CB-1:0] rx, ry, rz;
    p = $urandom_range(0, 99);
    if (p < 10) begin
      {rz, ry, rx} = prev_sat[3*CB-1:0];
      send_sat(rx, ry, rz, last);
    end else if (p < 30) begin
      send_sat(rnd_coord(), rnd_coord(), rnd_coord(), last);
    end else begin
      send_sat($signed($urandom_range(0, 1 << 21)) - (1 << 20),
               $signed($urandom_range(0, 1 << 21)) - (1 << 20),
               axis_sign * (axis_r + $urandom_range(0, 1 << 20)) -
               axis_sign * $urandom_range(0, 3) * (1 << 18), last);
    end
  endtask

  task automatic random_run(input int n);
    for (int i = 1; i <= n; i++) random_sat(i == n);
  endtask

  initial begin
    longint u0;
    u0 = 64'sd1 <<< 26;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zenith user, quarter cone
    set_user(0, 0, u0);
    write_reg(REG_HORIZON, CFG_DATA_W'(u0 * u0));
    write_reg(REG_CONE, CFG_DATA_W'(u0 * u0 / 4));
    send_sat(0, 0, u0 + 1000, 1'b0);
    send_sat(0, 0, u0 + 1000, 1'b0);
    send_sat(500, 0, u0 + 1000, 1'b0);
    send_sat(0, 0, u0 + 300, 1'b0);
    send_sat(CMAX, CMAX, CMAX, 1'b0);
    send_sat(CMIN, CMIN, CMIN, 1'b0);
    send_sat(0, 0, 0, 1'b0);
    send_sat(0, 0, u0 - 1, 1'b0);
    send_sat(CMAX, 0, u0 + 10, 1'b0);
    send_sat(0, 0, CMAX, 1'b1);
    // nothing visible
    send_sat(CMIN, CMIN, CMIN, 1'b1);
    drain();

    // extreme registers, and an ignored index
    set_user(CMIN, CMAX, CMIN);
    write_reg(REG_HORIZON, CFG_DATA_W'(THR_MAX));
    write_reg(REG_CONE, CFG_DATA_W'(THR_MAX));
    write_reg(CFG_IDX_W'(REG_CONE) + CFG_IDX_W'($urandom_range(1, 3)), '1);
    send_sat(CMIN, CMAX, CMIN, 1'b0);
    send_sat(CMAX, CMIN, CMAX, 1'b0);
    send_sat(CMIN, CMAX, CMAX, 1'b1);
    drain();
    set_user(CMAX, CMIN, CMAX);
    write_reg(REG_HORIZON, '0);
    write_reg(REG_CONE, '0);
    send_sat(CMAX, CMIN, CMAX + 0, 1'b0);
    send_sat(CMAX, CMIN, CMIN, 1'b0);
    send_sat(CMIN, CMAX, CMIN, 1'b1);
    drain();
    set_user(0, 0, 0);
    send_sat(5, 5, 5, 1'b1);
    drain();

    // capacity: exact fill, one beyond, well beyond
    write_reg(REG_USER_X, CFG_DATA_W'({$urandom(), $urandom()}));
    geometric_config();
    write_reg(REG_CONE, '0);
    random_run(MAX_SATS_DEF);
    drain();
    random_run(MAX_SATS_DEF + 1);
    drain();
    random_run(MAX_SATS_DEF + 6);
    drain();

    // random phases; one of them under a long output hold-off
    for (int ph = 0; sats_sent < 300; ph++) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) begin
        set_user(rnd_coord(), rnd_coord(), rnd_coord());
        write_reg(REG_HORIZON, CFG_DATA_W'($urandom_range(0, 1 << 30)));
        write_reg(REG_CONE, CFG_DATA_W'({$urandom(), $urandom()}));
      end else begin
        geometric_config();
      end
      if (ph == 1) hold_req = 1'b1;
      repeat ($urandom_range(1, 4)) random_run($urandom_range(1, 12));
      drain();
    end

    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== visible_satellite_select_sort.f =====
rtl/core/vss_pkg.sv
rtl/core/vss_mem.sv
rtl/core/vss_calc.sv
rtl/core/visible_satellite_select_sort.sv
rtl/core/vss_checker.sv
tb/visible_satellite_select_chk.sv
tb/tb_visible_satellite_select_sort.sv
